FILE: hdl/text_console_cursor_engine_assert.svh
// ----------------------------------------------------------------------------
// text console cursor engine assertion macros
// concurrent checks on the clock, disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define TCCE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define TCCE_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define TCCE_ASSERT(label, clk, rst, prop, msg)

`define TCCE_ASSERT_NEXT(label, clk, rst, pre, post, msg)

`endif

`endif

FILE: hdl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// character codes, reset colour and shared types of the cursor engine
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] PRINT_LO   = 8'h20;
   localparam logic [7:0] PRINT_HI   = 8'h7E;
   localparam logic [7:0] DIGIT_LO   = 8'h30;
   localparam logic [7:0] DIGIT_HI   = 8'h39;
   localparam logic [7:0] UPPER_LO   = 8'h41;
   localparam logic [7:0] UPPER_HI   = 8'h46;
   localparam logic [7:0] LOWER_LO   = 8'h61;
   localparam logic [7:0] LOWER_HI   = 8'h66;
   localparam logic [3:0] HEX_ALPHA  = 4'd9;
   localparam logic [3:0] COLOR_RESET = 4'd7;

   typedef struct packed {
      logic       is_bs;
      logic       is_tab;
      logic       is_lf;
      logic       is_cr;
      logic       is_ff;
      logic       is_print;
      logic       is_hex;
      logic [3:0] hex_val;
   } char_class_type;

   typedef struct packed {
      logic       draw_valid;
      logic [7:0] draw_x;
      logic [7:0] draw_y;
      logic [6:0] glyph;
      logic [3:0] draw_color;
      logic       scroll_up;
      logic [7:0] cursor_col;
      logic [7:0] cursor_row;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hdl/tcce_decode.sv
// ----------------------------------------------------------------------------
// tcce_decode
// classifies a character byte into controls, printable range and hex digit
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_decode (
   input  wire logic [7:0]               char_code,
   output tcce_pkg::char_class_type      cls
);

   logic is_digit;
   logic is_upper;
   logic is_lower;

   assign is_digit = (char_code >= tcce_pkg::DIGIT_LO) && (char_code <= tcce_pkg::DIGIT_HI);
   assign is_upper = (char_code >= tcce_pkg::UPPER_LO) && (char_code <= tcce_pkg::UPPER_HI);
   assign is_lower = (char_code >= tcce_pkg::LOWER_LO) && (char_code <= tcce_pkg::LOWER_HI);

   always_comb begin
      cls.is_bs    = (char_code == tcce_pkg::CHAR_BS);
      cls.is_tab   = (char_code == tcce_pkg::CHAR_TAB);
      cls.is_lf    = (char_code == tcce_pkg::CHAR_LF);
      cls.is_cr    = (char_code == tcce_pkg::CHAR_CR);
      cls.is_ff    = (char_code == tcce_pkg::CHAR_FF);
      cls.is_print = (char_code >= tcce_pkg::PRINT_LO) && (char_code <= tcce_pkg::PRINT_HI);
      cls.is_hex   = is_digit || is_upper || is_lower;
      // letters a-f and A-F share their low nibble, offset by nine
      cls.hex_val  = is_digit ? char_code[3:0] : (char_code[3:0] + tcce_pkg::HEX_ALPHA);
   end

endmodule

`default_nettype wire

FILE: hdl/tcce_move.sv
// ----------------------------------------------------------------------------
// tcce_move
// next cursor, colour and escape state plus the result of one character
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_move #(
   parameter int SCREEN_WIDTH  = 200,
   parameter int SCREEN_HEIGHT = 161,
   parameter int CELL_WIDTH    = 4,
   parameter int LINE_HEIGHT   = 7,
   parameter int TAB_STEP      = 16
) (
   input  wire logic [$clog2(SCREEN_WIDTH)-1:0]              col,
   input  wire logic [$clog2(SCREEN_HEIGHT+LINE_HEIGHT)-1:0] row,
   input  wire logic [3:0]                                   color,
   input  wire logic                                         pending,
   input  wire logic [6:0]                                   char_low,
   input  wire tcce_pkg::char_class_type                     cls,
   output logic [$clog2(SCREEN_WIDTH)-1:0]                   nxt_col,
   output logic [$clog2(SCREEN_HEIGHT+LINE_HEIGHT)-1:0]      nxt_row,
   output logic [3:0]                                        nxt_color,
   output logic                                              nxt_pending,
   output tcce_pkg::rsp_type                                 rsp
);

   localparam int COL_W     = $clog2(SCREEN_WIDTH);
   localparam int ROW_W     = $clog2(SCREEN_HEIGHT + LINE_HEIGHT);
   localparam int XW        = $clog2(SCREEN_WIDTH + TAB_STEP + CELL_WIDTH) + 1;
   localparam int YW        = $clog2(SCREEN_HEIGHT + 2 * LINE_HEIGHT) + 1;
   localparam int TAB_SHIFT = COL_W + 7;
   localparam int PW        = COL_W + TAB_SHIFT;

   localparam logic [PW-1:0]        TAB_RECIP = PW'((1 << TAB_SHIFT) / TAB_STEP + 1);
   localparam logic [XW-1:0]        TAB_X     = XW'(TAB_STEP);
   localparam logic signed [XW-1:0] CELL_X    = XW'(CELL_WIDTH);
   localparam logic signed [XW-1:0] W_X       = XW'(SCREEN_WIDTH);
   localparam logic signed [YW-1:0] LH_Y      = YW'(LINE_HEIGHT);
   localparam logic signed [YW-1:0] SH_Y      = YW'(SCREEN_HEIGHT);

   logic [PW-1:0]        tab_prod;
   logic [COL_W-1:0]     tab_q;
   logic [XW-1:0]        tab_u;
   logic signed [XW-1:0] x0;
   logic signed [XW-1:0] x1;
   logic signed [XW-1:0] x2;
   logic signed [YW-1:0] y0;
   logic signed [YW-1:0] y1;
   logic signed [YW-1:0] y2;
   logic signed [YW-1:0] y3;
   logic signed [YW-1:0] y4;
   logic                 scroll;

   // next tab stop: quotient by reciprocal multiplication
   assign tab_prod = PW'(col) * TAB_RECIP;
   assign tab_q    = tab_prod[PW-1:TAB_SHIFT];
   assign tab_u    = (XW'(tab_q) + XW'(1)) * TAB_X;

   always_comb begin
      x0          = $signed({{(XW-COL_W){1'b0}}, col});
      y0          = $signed({{(YW-ROW_W){1'b0}}, row});
      x1          = x0;
      y1          = y0;
      nxt_color   = color;
      nxt_pending = pending;
      rsp         = '0;

      if (cls.is_bs) begin
         x1 = x0 - CELL_X;
      end else if (cls.is_tab) begin
         x1 = $signed(tab_u);
      end else if (cls.is_lf) begin
         y1 = y0 + LH_Y;
      end else if (cls.is_cr) begin
         x1 = '0;
      end else if (cls.is_ff) begin
         nxt_pending = 1'b1;
      end else if (pending) begin
         if (cls.is_hex) begin
            nxt_color = cls.hex_val;
         end
         nxt_pending = 1'b0;
      end else if (cls.is_print) begin
         rsp.draw_valid = 1'b1;
         rsp.draw_x     = 8'(col);
         rsp.draw_y     = 8'(row);
         rsp.glyph      = char_low;
         rsp.draw_color = color;
         x1             = x0 + CELL_X;
      end

      // horizontal wrap onto the previous or next line
      priority if (x1 < 0) begin
         x2 = x1 + W_X;
         y2 = y1 - LH_Y;
      end else if (x1 >= W_X) begin
         x2 = x1 - W_X;
         y2 = y1 + LH_Y;
      end else begin
         x2 = x1;
         y2 = y1;
      end

      y3 = (y2 < 0) ? '0 : y2;

      // past the bottom line: scroll and move up one line
      if ((y3 + LH_Y > SH_Y) && (y3 >= LH_Y)) begin
         y4     = y3 - LH_Y;
         scroll = 1'b1;
      end else begin
         y4     = y3;
         scroll = 1'b0;
      end

      nxt_col        = x2[COL_W-1:0];
      nxt_row        = y4[ROW_W-1:0];
      rsp.scroll_up  = scroll;
      rsp.cursor_col = 8'(x2[COL_W-1:0]);
      rsp.cursor_row = 8'(y4[ROW_W-1:0]);
   end

endmodule

`default_nettype wire

FILE: hdl/text_console_cursor_engine.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine: a character passes the input and output registers
// one character per cycle unless stalled, set by the cursor state loop
// synchronous reset: cursor 0,0, colour 7, no escape pending, both stages empty
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_engine #(
   parameter int SCREEN_WIDTH  = 200,
   parameter int SCREEN_HEIGHT = 161,
   parameter int CELL_WIDTH    = 4,
   parameter int LINE_HEIGHT   = 7,
   parameter int TAB_STEP      = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_char_code,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_draw_valid,
   output logic [7:0]      rsp_draw_x,
   output logic [7:0]      rsp_draw_y,
   output logic [6:0]      rsp_glyph,
   output logic [3:0]      rsp_draw_color,
   output logic            rsp_scroll_up,
   output logic [7:0]      rsp_cursor_col,
   output logic [7:0]      rsp_cursor_row
);

`include "text_console_cursor_engine_assert.svh"

   localparam int COL_W = $clog2(SCREEN_WIDTH);
   localparam int ROW_W = $clog2(SCREEN_HEIGHT + LINE_HEIGHT);

   logic                      in_valid_ff;
   logic [7:0]                in_char_ff;
   logic                      out_valid_ff;
   tcce_pkg::rsp_type         out_ff;
   tcce_pkg::rsp_type         out_in;
   logic [COL_W-1:0]          col_ff;
   logic [COL_W-1:0]          col_in;
   logic [ROW_W-1:0]          row_ff;
   logic [ROW_W-1:0]          row_in;
   logic [3:0]                color_ff;
   logic [3:0]                color_in;
   logic                      pending_ff;
   logic                      pending_in;
   tcce_pkg::char_class_type  cls;
   logic                      advance;
   logic                      fire;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = !advance;

   tcce_decode u_decode (
      .char_code (in_char_ff),
      .cls       (cls)
   );

   tcce_move #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .CELL_WIDTH    (CELL_WIDTH),
      .LINE_HEIGHT   (LINE_HEIGHT),
      .TAB_STEP      (TAB_STEP)
   ) u_move (
      .col         (col_ff),
      .row         (row_ff),
      .color       (color_ff),
      .pending     (pending_ff),
      .char_low    (in_char_ff[6:0]),
      .cls         (cls),
      .nxt_col     (col_in),
      .nxt_row     (row_in),
      .nxt_color   (color_in),
      .nxt_pending (pending_in),
      .rsp         (out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         color_ff     <= tcce_pkg::COLOR_RESET;
         pending_ff   <= 1'b0;
      end else begin
         if (advance) begin
            in_valid_ff <= req_valid;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
            col_ff       <= col_in;
            row_ff       <= row_in;
            color_ff     <= color_in;
            pending_ff   <= pending_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         in_char_ff <= req_char_code;
      end
      if (fire) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_draw_valid = out_ff.draw_valid;
   assign rsp_draw_x     = out_ff.draw_x;
   assign rsp_draw_y     = out_ff.draw_y;
   assign rsp_glyph      = out_ff.glyph;
   assign rsp_draw_color = out_ff.draw_color;
   assign rsp_scroll_up  = out_ff.scroll_up;
   assign rsp_cursor_col = out_ff.cursor_col;
   assign rsp_cursor_row = out_ff.cursor_row;

   `TCCE_ASSERT(a_col_in_screen, clock, reset, int'(col_ff) < SCREEN_WIDTH, "cursor column off screen")
   `TCCE_ASSERT(a_row_in_screen, clock, reset, (int'(row_ff) + LINE_HEIGHT <= SCREEN_HEIGHT) || (int'(row_ff) < LINE_HEIGHT), "cursor row below last line")
   `TCCE_ASSERT_NEXT(a_draw_no_escape, clock, reset, fire && out_in.draw_valid, !pending_ff, "draw left colour escape pending")

endmodule

`default_nettype wire
